// ===== rtl/i64alu_pkg.sv =====
package i64alu_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned OP_W   = 3;
    localparam int unsigned SHAMT_W = 6;

    // one cell per quotient or multiplier bit
    localparam int unsigned N_CELLS = DATA_W;

    localparam logic [OP_W-1:0] OP_SHL  = 3'd0;
    localparam logic [OP_W-1:0] OP_SRL  = 3'd1;
    localparam logic [OP_W-1:0] OP_SRA  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_SDIV = 3'd4;
    localparam logic [OP_W-1:0] OP_UDIV = 3'd5;
    localparam logic [OP_W-1:0] OP_SREM = 3'd6;
    localparam logic [OP_W-1:0] OP_UREM = 3'd7;

    // work carried from cell to cell
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] acc;    // partial remainder, product sum, or shift result
        logic [DATA_W-1:0] quo;    // dividend/quotient bits, or multiplier bits
        logic [DATA_W-1:0] dvs;    // divisor, or shifted multiplicand
        logic [DATA_W-1:0] orig;   // operand a, for remainder by zero
        logic              neg_q;
        logic              neg_r;
        logic              bzero;
    } stage_t;

endpackage

// ===== rtl/i64alu_if.sv =====
interface i64alu_req_if;
    logic                             valid;
    logic                             ready;
    logic [i64alu_pkg::OP_W-1:0]      opcode;
    logic [i64alu_pkg::DATA_W-1:0]    operand_a;
    logic [i64alu_pkg::DATA_W-1:0]    operand_b;

    modport source (output valid, output opcode, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input opcode, input operand_a, input operand_b,
                    output ready);
endinterface

interface i64alu_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [i64alu_pkg::DATA_W-1:0]    result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

// ===== rtl/i64alu_cell.sv =====
module i64alu_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  i64alu_pkg::stage_t  in_stage,
    output logic                out_valid,
    output i64alu_pkg::stage_t  out_stage
);

    logic                           valid_reg;
    i64alu_pkg::stage_t             stage_reg;
    i64alu_pkg::stage_t             stage_next;
    logic [i64alu_pkg::DATA_W:0]    shifted;
    logic [i64alu_pkg::DATA_W:0]    diff;

    always_comb
    begin
        stage_next = in_stage;
        shifted    = {in_stage.acc, in_stage.quo[i64alu_pkg::DATA_W-1]};
        diff       = shifted - {1'b0, in_stage.dvs};
        case (in_stage.op) inside
            i64alu_pkg::OP_MUL:
            begin
                // one shift-add step of the product
                if (in_stage.quo[0])
                begin
                    stage_next.acc = in_stage.acc + in_stage.dvs;
                end
                stage_next.dvs = {in_stage.dvs[i64alu_pkg::DATA_W-2:0], 1'b0};
                stage_next.quo = {1'b0, in_stage.quo[i64alu_pkg::DATA_W-1:1]};
            end
            i64alu_pkg::OP_SDIV, i64alu_pkg::OP_UDIV,
            i64alu_pkg::OP_SREM, i64alu_pkg::OP_UREM:
            begin
                // one restoring division step
                if (!diff[i64alu_pkg::DATA_W])
                begin
                    stage_next.acc = diff[i64alu_pkg::DATA_W-1:0];
                end
                else
                begin
                    stage_next.acc = shifted[i64alu_pkg::DATA_W-1:0];
                end
                stage_next.quo = {in_stage.quo[i64alu_pkg::DATA_W-2:0],
                                  ~diff[i64alu_pkg::DATA_W]};
            end
            default:
            begin
                stage_next = in_stage;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// ===== rtl/int64_mul_div_rem_shift_alu.sv =====
// channel | dir | payload                          | transfer when
// req     | in  | opcode, operand_a, operand_b     | req.valid && req.ready
// rsp     | out | result                           | rsp.valid && rsp.ready
//
// one operation enters per cycle unless the queue is full
// a row of 64 registered cells does one multiply or divide bit per cell
// shifts are done at the front and ride through the row unchanged
// a two-entry output queue takes results; the row stalls only when the queue is full
// rst_n clears the cell valid bits and the queue, asynchronously
module int64_mul_div_rem_shift_alu (
    input  logic                 clk,
    input  logic                 rst_n,
    i64alu_req_if.sink           req,
    i64alu_rsp_if.source         rsp
);

    localparam int unsigned W = i64alu_pkg::DATA_W;
    localparam int unsigned N_CELLS = i64alu_pkg::N_CELLS;

    logic                 en;
    i64alu_pkg::stage_t   prep;
    logic [W-1:0]         mag_a;
    logic [W-1:0]         mag_b;
    logic [i64alu_pkg::SHAMT_W-1:0] shamt;
    logic                 sgn_op;

    logic                 cell_valid [N_CELLS+1];
    i64alu_pkg::stage_t   cell_stage [N_CELLS+1];

    i64alu_pkg::stage_t   last;
    logic [W-1:0]         fixed;

    // output queue
    logic [W-1:0]         buf_reg [2];
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic [1:0]           cnt_reg;
    logic [1:0]           cnt_next;
    logic                 push;
    logic                 pop;

    assign en        = (cnt_reg != 2'd2);
    assign req.ready = en;

    // front end: shifts, operand magnitudes and sign fixups
    always_comb
    begin
        shamt  = req.operand_b[i64alu_pkg::SHAMT_W-1:0];
        sgn_op = (req.opcode == i64alu_pkg::OP_SDIV) || (req.opcode == i64alu_pkg::OP_SREM);
        mag_a  = (sgn_op && req.operand_a[W-1]) ? (W'(0) - req.operand_a) : req.operand_a;
        mag_b  = (sgn_op && req.operand_b[W-1]) ? (W'(0) - req.operand_b) : req.operand_b;

        prep.op    = req.opcode;
        prep.acc   = '0;
        prep.quo   = mag_a;
        prep.dvs   = mag_b;
        prep.orig  = req.operand_a;
        prep.neg_q = req.operand_a[W-1] ^ req.operand_b[W-1];
        prep.neg_r = req.operand_a[W-1];
        prep.bzero = (req.operand_b == '0);

        unique case (req.opcode)
            i64alu_pkg::OP_SHL:  prep.acc = req.operand_a << shamt;
            i64alu_pkg::OP_SRL:  prep.acc = req.operand_a >> shamt;
            i64alu_pkg::OP_SRA:  prep.acc = W'($signed(req.operand_a) >>> shamt);
            i64alu_pkg::OP_MUL:
            begin
                // multiplicand shifts left, multiplier bits shift right
                prep.dvs = req.operand_a;
                prep.quo = req.operand_b;
            end
            default:             prep.acc = '0;
        endcase
    end

    assign cell_valid[0] = req.valid;
    assign cell_stage[0] = prep;

    for (genvar i = 0; i < N_CELLS; i++)
    begin : g_cell
        i64alu_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (cell_valid[i]),
            .in_stage  (cell_stage[i]),
            .out_valid (cell_valid[i+1]),
            .out_stage (cell_stage[i+1])
        );
    end

    // back end: signs and the divide-by-zero cases
    assign last = cell_stage[N_CELLS];

    always_comb
    begin
        case (last.op)
            i64alu_pkg::OP_SDIV:
                fixed = last.bzero ? '0 : (last.neg_q ? (W'(0) - last.quo) : last.quo);
            i64alu_pkg::OP_UDIV:
                fixed = last.bzero ? '0 : last.quo;
            i64alu_pkg::OP_SREM:
                fixed = last.bzero ? last.orig : (last.neg_r ? (W'(0) - last.acc) : last.acc);
            i64alu_pkg::OP_UREM:
                fixed = last.bzero ? last.orig : last.acc;
            default:
                fixed = last.acc;
        endcase
    end

    assign push = cell_valid[N_CELLS] && en;
    assign pop  = rsp.valid && rsp.ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= fixed;
        end
    end

    assign rsp.valid  = (cnt_reg != 2'd0);
    assign rsp.result = buf_reg[rd_ptr_reg];

endmodule
